@@ design/gcm_pkg.sv @@
// shared constants, types and arithmetic helpers for the great-circle midpoint block
package gcm_pkg;

    localparam int LAT_W      = 17;
    localparam int LON_W      = 18;
    localparam int MID_LON_W  = 19;
    localparam int ANGLES     = 3;

    localparam int WORK_BITS  = 30;
    localparam int CW         = 35;
    localparam int MW         = 34;
    localparam int TABLE_LEN  = 28;

    localparam int DEFAULT_ANGLE_FRACTION_BITS = 15;
    localparam int DEFAULT_ROTATION_STAGES     = 16;

    localparam longint Q_ONE      = 64'sd1073741824;
    localparam longint Q_PI       = 64'sd3373259426;
    localparam longint Q_HALF_PI  = 64'sd1686629713;
    localparam longint Q_INV_GAIN = 64'sd652032874;

    localparam logic signed [CW-1:0] PI_W      = CW'(Q_PI);
    localparam logic signed [CW-1:0] HALF_PI_W = CW'(Q_HALF_PI);
    localparam logic signed [MW-1:0] INV_GAIN  = MW'(Q_INV_GAIN);

    localparam longint ARC_TABLE [TABLE_LEN] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    // q30 product, rounded half up with floor shift
    function automatic logic signed [MW-1:0] qmul(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = a * b;
        p = p + ((2*MW)'(1) <<< (WORK_BITS - 1));
        return MW'(p >>> WORK_BITS);
    endfunction

    // turn the vector by pi when the abscissa is negative
    function automatic cordic_t vec_prep(input logic signed [CW-1:0] y_in,
                                         input logic signed [CW-1:0] x_in);
        cordic_t r;
        if (x_in[CW-1])
        begin
            r.x = -x_in;
            r.y = -y_in;
            r.z = y_in[CW-1] ? -PI_W : PI_W;
        end
        else
        begin
            r.x = x_in;
            r.y = y_in;
            r.z = '0;
        end
        return r;
    endfunction

endpackage

@@ design/great_circle_midpoint.sv @@
// great-circle midpoint top level: reduction, sin/cos, products, two atan2 chains
// Takes one pair of points per cycle while src_stall is low and returns one
// midpoint per pair, in order. Stages: input register, whole-turn reduction
// cells (TURN_STEPS = 18 - ANGLE_FRACTION_BITS, at least one), half-turn fold,
// rotation cells for three sin/cos pairs, two gain and product stages, then
// set-up, vectoring cells and norm for the longitude arc and set-up and
// vectoring cells for the latitude arc. A two-beat output queue keeps the input
// open while a result waits; the input stalls only when that queue is full.
module great_circle_midpoint
    import gcm_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = DEFAULT_ANGLE_FRACTION_BITS,
    parameter int ROTATION_STAGES     = DEFAULT_ROTATION_STAGES
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic signed [LAT_W-1:0]      start_latitude,
    input  logic signed [LON_W-1:0]      start_longitude,
    input  logic signed [LAT_W-1:0]      end_latitude,
    input  logic signed [LON_W-1:0]      end_longitude,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic signed [LAT_W-1:0]      middle_latitude,
    output logic signed [MID_LON_W-1:0]  middle_longitude
);

    localparam int SHIFT      = WORK_BITS - ANGLE_FRACTION_BITS;
    localparam int RW         = (51 - ANGLE_FRACTION_BITS > CW) ? 51 - ANGLE_FRACTION_BITS : CW;
    localparam int TURN_STEPS = (18 - ANGLE_FRACTION_BITS > 1) ? 18 - ANGLE_FRACTION_BITS : 1;
    localparam int RS         = ROTATION_STAGES;
    localparam int ROT_SW     = LON_W + ANGLES;
    localparam int VEC_SW     = LON_W + CW + 1;

    localparam logic signed [CW-1:0] ROUND_HALF = CW'(longint'(1) << (SHIFT - 1));
    localparam logic signed [CW-1:0] LAT_HI = CW'((longint'(1) << (LAT_W - 1)) - 1);
    localparam logic signed [CW-1:0] LAT_LO = CW'(-(longint'(1) << (LAT_W - 1)));
    localparam logic signed [CW:0]   LON_HI = (CW+1)'((longint'(1) << (MID_LON_W - 1)) - 1);
    localparam logic signed [CW:0]   LON_LO = (CW+1)'(-(longint'(1) << (MID_LON_W - 1)));

    logic en;

    // input register
    logic                       s0_valid_reg;
    logic                       s0_valid_next;
    logic [ANGLES-1:0][RW-1:0]  s0_theta_reg;
    logic [ANGLES-1:0][RW-1:0]  s0_theta_next;
    logic signed [LON_W-1:0]    s0_lon_reg;
    logic signed [LON_W:0]      lon_diff;

    always_comb
    begin
        s0_valid_next    = en ? src_valid : s0_valid_reg;
        lon_diff         = (LON_W+1)'(end_longitude) - (LON_W+1)'(start_longitude);
        s0_theta_next[0] = RW'(start_latitude) <<< SHIFT;
        s0_theta_next[1] = RW'(end_latitude) <<< SHIFT;
        s0_theta_next[2] = RW'(lon_diff) <<< SHIFT;
    end

    // whole-turn reduction chain
    logic                       turn_valid [TURN_STEPS+1];
    logic [ANGLES-1:0][RW-1:0]  turn_theta [TURN_STEPS+1];
    logic [LON_W-1:0]           turn_side  [TURN_STEPS+1];

    assign turn_valid[0] = s0_valid_reg;
    assign turn_theta[0] = s0_theta_reg;
    assign turn_side[0]  = s0_lon_reg;

    genvar gi;
    for (gi = 0; gi < TURN_STEPS; gi++)
    begin : g_turn
        gcm_turn_cell #(
            .RW     (RW),
            .STEP   (TURN_STEPS - 1 - gi),
            .SIDE_W (LON_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (turn_valid[gi]),
            .in_theta  (turn_theta[gi]),
            .in_side   (turn_side[gi]),
            .out_valid (turn_valid[gi+1]),
            .out_theta (turn_theta[gi+1]),
            .out_side  (turn_side[gi+1])
        );
    end

    // half-turn fold into [-pi/2, pi/2]
    logic                   fold_valid_reg;
    logic                   fold_valid_next;
    cordic_t [ANGLES-1:0]   fold_data_reg;
    cordic_t [ANGLES-1:0]   fold_data_next;
    logic [ROT_SW-1:0]      fold_side_reg;
    logic [ROT_SW-1:0]      fold_side_next;
    logic [ANGLES-1:0]      fold_flip;
    logic signed [CW-1:0]   fold_t [ANGLES];

    always_comb
    begin
        fold_valid_next = en ? turn_valid[TURN_STEPS] : fold_valid_reg;
        for (int l = 0; l < ANGLES; l++)
        begin
            fold_t[l] = CW'($signed(turn_theta[TURN_STEPS][l]));
            fold_data_next[l].x = CW'(Q_ONE);
            fold_data_next[l].y = '0;
            if (fold_t[l] > HALF_PI_W)
            begin
                fold_data_next[l].z = fold_t[l] - PI_W;
                fold_flip[l] = 1'b1;
            end
            else if (fold_t[l] < -HALF_PI_W)
            begin
                fold_data_next[l].z = fold_t[l] + PI_W;
                fold_flip[l] = 1'b1;
            end
            else
            begin
                fold_data_next[l].z = fold_t[l];
                fold_flip[l] = 1'b0;
            end
        end
        fold_side_next = {turn_side[TURN_STEPS], fold_flip};
    end

    // sin/cos rotation chain
    logic                   rot_valid [RS+1];
    cordic_t [ANGLES-1:0]   rot_data  [RS+1];
    logic [ROT_SW-1:0]      rot_side  [RS+1];

    assign rot_valid[0] = fold_valid_reg;
    assign rot_data[0]  = fold_data_reg;
    assign rot_side[0]  = fold_side_reg;

    for (gi = 0; gi < RS; gi++)
    begin : g_rot
        gcm_cordic_cell #(
            .STAGE     (gi),
            .LANES     (ANGLES),
            .VECTORING (1'b0),
            .SIDE_W    (ROT_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rot_valid[gi]),
            .in_data   (rot_data[gi]),
            .in_side   (rot_side[gi]),
            .out_valid (rot_valid[gi+1]),
            .out_data  (rot_data[gi+1]),
            .out_side  (rot_side[gi+1])
        );
    end

    // gain removal, lane 0 start latitude, 1 end latitude, 2 longitude difference
    logic                   g1_valid_reg;
    logic                   g1_valid_next;
    logic signed [MW-1:0]   g1_sin_reg  [ANGLES];
    logic signed [MW-1:0]   g1_cos_reg  [ANGLES];
    logic signed [MW-1:0]   g1_sin_next [ANGLES];
    logic signed [MW-1:0]   g1_cos_next [ANGLES];
    logic signed [MW-1:0]   g1_xm [ANGLES];
    logic signed [MW-1:0]   g1_ym [ANGLES];
    logic [LON_W-1:0]       g1_lon_reg;

    always_comb
    begin
        g1_valid_next = en ? rot_valid[RS] : g1_valid_reg;
        for (int l = 0; l < ANGLES; l++)
        begin
            g1_xm[l] = qmul(MW'(rot_data[RS][l].x), INV_GAIN);
            g1_ym[l] = qmul(MW'(rot_data[RS][l].y), INV_GAIN);
            g1_cos_next[l] = rot_side[RS][l] ? -g1_xm[l] : g1_xm[l];
            g1_sin_next[l] = rot_side[RS][l] ? -g1_ym[l] : g1_ym[l];
        end
    end

    // bx, by and the summed latitude sines
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic signed [MW-1:0]   m_bx_reg;
    logic signed [MW-1:0]   m_by_reg;
    logic signed [MW-1:0]   m_c1_reg;
    logic signed [MW-1:0]   m_ys_reg;
    logic signed [MW-1:0]   m_bx_next;
    logic signed [MW-1:0]   m_by_next;
    logic signed [MW-1:0]   m_ys_next;
    logic [LON_W-1:0]       m_lon_reg;

    always_comb
    begin
        m_valid_next = en ? g1_valid_reg : m_valid_reg;
        m_bx_next    = qmul(g1_cos_reg[1], g1_cos_reg[2]);
        m_by_next    = qmul(g1_cos_reg[1], g1_sin_reg[2]);
        m_ys_next    = g1_sin_reg[0] + g1_sin_reg[1];
    end

    // first atan2 set-up
    logic                   f1_valid_reg;
    logic                   f1_valid_next;
    cordic_t [0:0]          f1_data_reg;
    cordic_t [0:0]          f1_data_next;
    logic [VEC_SW-1:0]      f1_side_reg;
    logic [VEC_SW-1:0]      f1_side_next;
    logic signed [CW-1:0]   f1_cx;
    logic signed [CW-1:0]   f1_by;

    always_comb
    begin
        f1_valid_next   = en ? m_valid_reg : f1_valid_reg;
        f1_cx           = CW'(m_c1_reg) + CW'(m_bx_reg);
        f1_by           = CW'(m_by_reg);
        f1_data_next[0] = vec_prep(f1_by, f1_cx);
        f1_side_next    = {m_lon_reg, CW'(m_ys_reg), (f1_cx == '0) && (f1_by == '0)};
    end

    logic               v1_valid [RS+1];
    cordic_t [0:0]      v1_data  [RS+1];
    logic [VEC_SW-1:0]  v1_side  [RS+1];

    assign v1_valid[0] = f1_valid_reg;
    assign v1_data[0]  = f1_data_reg;
    assign v1_side[0]  = f1_side_reg;

    for (gi = 0; gi < RS; gi++)
    begin : g_vec1
        gcm_cordic_cell #(
            .STAGE     (gi),
            .LANES     (1),
            .VECTORING (1'b1),
            .SIDE_W    (VEC_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v1_valid[gi]),
            .in_data   (v1_data[gi]),
            .in_side   (v1_side[gi]),
            .out_valid (v1_valid[gi+1]),
            .out_data  (v1_data[gi+1]),
            .out_side  (v1_side[gi+1])
        );
    end

    // norm and midpoint longitude arc
    logic                   g2_valid_reg;
    logic                   g2_valid_next;
    logic signed [CW-1:0]   g2_norm_reg;
    logic signed [CW-1:0]   g2_norm_next;
    logic signed [CW-1:0]   g2_zlon_reg;
    logic signed [CW-1:0]   g2_zlon_next;
    logic [CW-1:0]          g2_ys_reg;
    logic [LON_W-1:0]       g2_lon_reg;
    logic                   g2_zero;

    always_comb
    begin
        g2_valid_next = en ? v1_valid[RS] : g2_valid_reg;
        g2_zero       = v1_side[RS][0];
        g2_norm_next  = g2_zero ? '0 : CW'(qmul(MW'(v1_data[RS][0].x), INV_GAIN));
        g2_zlon_next  = g2_zero ? '0 : v1_data[RS][0].z;
    end

    // second atan2 set-up
    logic                   f2_valid_reg;
    logic                   f2_valid_next;
    cordic_t [0:0]          f2_data_reg;
    cordic_t [0:0]          f2_data_next;
    logic [VEC_SW-1:0]      f2_side_reg;
    logic [VEC_SW-1:0]      f2_side_next;

    always_comb
    begin
        f2_valid_next   = en ? g2_valid_reg : f2_valid_reg;
        f2_data_next[0] = vec_prep($signed(g2_ys_reg), g2_norm_reg);
        f2_side_next    = {g2_lon_reg, g2_zlon_reg,
                           (g2_ys_reg == '0) && (g2_norm_reg == '0)};
    end

    logic               v2_valid [RS+1];
    cordic_t [0:0]      v2_data  [RS+1];
    logic [VEC_SW-1:0]  v2_side  [RS+1];

    assign v2_valid[0] = f2_valid_reg;
    assign v2_data[0]  = f2_data_reg;
    assign v2_side[0]  = f2_side_reg;

    for (gi = 0; gi < RS; gi++)
    begin : g_vec2
        gcm_cordic_cell #(
            .STAGE     (gi),
            .LANES     (1),
            .VECTORING (1'b1),
            .SIDE_W    (VEC_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v2_valid[gi]),
            .in_data   (v2_data[gi]),
            .in_side   (v2_side[gi]),
            .out_valid (v2_valid[gi+1]),
            .out_data  (v2_data[gi+1]),
            .out_side  (v2_side[gi+1])
        );
    end

    // rounding to the angle format and saturation
    logic signed [CW-1:0]           out_zlat;
    logic signed [CW-1:0]           out_lat_r;
    logic signed [CW-1:0]           out_lon_r;
    logic signed [CW:0]             out_lon_sum;
    logic signed [LAT_W-1:0]        out_lat;
    logic signed [MID_LON_W-1:0]    out_lon;

    always_comb
    begin
        out_zlat    = v2_side[RS][0] ? '0 : v2_data[RS][0].z;
        out_lat_r   = (out_zlat + ROUND_HALF) >>> SHIFT;
        out_lon_r   = ($signed(v2_side[RS][CW:1]) + ROUND_HALF) >>> SHIFT;
        out_lon_sum = (CW+1)'($signed(v2_side[RS][VEC_SW-1 -: LON_W])) + (CW+1)'(out_lon_r);
        if (out_lat_r > LAT_HI)
            out_lat = LAT_W'(LAT_HI);
        else if (out_lat_r < LAT_LO)
            out_lat = LAT_W'(LAT_LO);
        else
            out_lat = LAT_W'(out_lat_r);
        if (out_lon_sum > LON_HI)
            out_lon = MID_LON_W'(LON_HI);
        else if (out_lon_sum < LON_LO)
            out_lon = MID_LON_W'(LON_LO);
        else
            out_lon = MID_LON_W'(out_lon_sum);
    end

    // two-beat output queue
    logic                           q_push;
    logic                           q_pop;
    logic [1:0]                     q_cnt_reg;
    logic [1:0]                     q_cnt_next;
    logic                           q_wr_reg;
    logic                           q_wr_next;
    logic                           q_rd_reg;
    logic                           q_rd_next;
    logic signed [LAT_W-1:0]        q_lat_reg [2];
    logic signed [MID_LON_W-1:0]    q_lon_reg [2];

    assign en        = (q_cnt_reg != 2'd2);
    assign src_stall = ~en;
    assign q_push    = en && v2_valid[RS];
    assign q_pop     = dst_valid && !dst_stall;

    always_comb
    begin
        q_wr_next  = q_push ? ~q_wr_reg : q_wr_reg;
        q_rd_next  = q_pop ? ~q_rd_reg : q_rd_reg;
        q_cnt_next = q_cnt_reg + 2'(q_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            fold_valid_reg <= 1'b0;
            g1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            f1_valid_reg   <= 1'b0;
            g2_valid_reg   <= 1'b0;
            f2_valid_reg   <= 1'b0;
            q_cnt_reg      <= 2'd0;
            q_wr_reg       <= 1'b0;
            q_rd_reg       <= 1'b0;
        end
        else
        begin
            s0_valid_reg   <= s0_valid_next;
            fold_valid_reg <= fold_valid_next;
            g1_valid_reg   <= g1_valid_next;
            m_valid_reg    <= m_valid_next;
            f1_valid_reg   <= f1_valid_next;
            g2_valid_reg   <= g2_valid_next;
            f2_valid_reg   <= f2_valid_next;
            q_cnt_reg      <= q_cnt_next;
            q_wr_reg       <= q_wr_next;
            q_rd_reg       <= q_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_theta_reg  <= s0_theta_next;
            s0_lon_reg    <= start_longitude;
            fold_data_reg <= fold_data_next;
            fold_side_reg <= fold_side_next;
            g1_sin_reg    <= g1_sin_next;
            g1_cos_reg    <= g1_cos_next;
            g1_lon_reg    <= rot_side[RS][ROT_SW-1 -: LON_W];
            m_bx_reg      <= m_bx_next;
            m_by_reg      <= m_by_next;
            m_c1_reg      <= g1_cos_reg[0];
            m_ys_reg      <= m_ys_next;
            m_lon_reg     <= g1_lon_reg;
            f1_data_reg   <= f1_data_next;
            f1_side_reg   <= f1_side_next;
            g2_norm_reg   <= g2_norm_next;
            g2_zlon_reg   <= g2_zlon_next;
            g2_ys_reg     <= v1_side[RS][CW:1];
            g2_lon_reg    <= v1_side[RS][VEC_SW-1 -: LON_W];
            f2_data_reg   <= f2_data_next;
            f2_side_reg   <= f2_side_next;
        end
        if (q_push)
        begin
            q_lat_reg[q_wr_reg] <= out_lat;
            q_lon_reg[q_wr_reg] <= out_lon;
        end
    end

    assign dst_valid        = (q_cnt_reg != 2'd0);
    assign middle_latitude  = q_lat_reg[q_rd_reg];
    assign middle_longitude = q_lon_reg[q_rd_reg];

endmodule

@@ design/gcm_turn_cell.sv @@
// one step of whole-turn angle reduction, three angles side by side
module gcm_turn_cell
    import gcm_pkg::*;
#(
    parameter int RW     = 40,
    parameter int STEP   = 0,
    parameter int SIDE_W = 18
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ANGLES-1:0][RW-1:0]   in_theta,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [ANGLES-1:0][RW-1:0]   out_theta,
    output logic [SIDE_W-1:0]           out_side
);

    // angles above pi*(2^(k+1)-1) lose 2^k whole turns, those at or below its negative gain them
    localparam longint BOUND_L = Q_PI * ((longint'(2) << STEP) - 1);
    localparam longint TURN_L  = (2 * Q_PI) << STEP;
    localparam logic signed [RW-1:0] BOUND = RW'(BOUND_L);
    localparam logic signed [RW-1:0] TURN  = RW'(TURN_L);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ANGLES-1:0][RW-1:0]  theta_reg;
    logic [ANGLES-1:0][RW-1:0]  theta_next;
    logic [SIDE_W-1:0]          side_reg;

    always_comb
    begin
        valid_next = en ? in_valid : valid_reg;
        for (int l = 0; l < ANGLES; l++)
        begin
            if ($signed(in_theta[l]) > BOUND)
                theta_next[l] = $signed(in_theta[l]) - TURN;
            else if ($signed(in_theta[l]) <= -BOUND)
                theta_next[l] = $signed(in_theta[l]) + TURN;
            else
                theta_next[l] = in_theta[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= theta_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_theta = theta_reg;
    assign out_side  = side_reg;

endmodule

@@ design/gcm_cordic_cell.sv @@
// one shift-add cordic step, rotation or vectoring, over LANES parallel lanes
module gcm_cordic_cell
    import gcm_pkg::*;
#(
    parameter int STAGE     = 0,
    parameter int LANES     = 1,
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 1
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  cordic_t [LANES-1:0]     in_data,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output cordic_t [LANES-1:0]     out_data,
    output logic [SIDE_W-1:0]       out_side
);

    localparam logic signed [CW-1:0] ARC = CW'(ARC_TABLE[STAGE]);

    logic                   valid_reg;
    logic                   valid_next;
    cordic_t [LANES-1:0]    data_reg;
    cordic_t [LANES-1:0]    data_next;
    logic [SIDE_W-1:0]      side_reg;
    logic [LANES-1:0]       turn_pos;

    always_comb
    begin
        valid_next = en ? in_valid : valid_reg;
        for (int l = 0; l < LANES; l++)
        begin
            // rotation follows z, vectoring drives y towards zero
            turn_pos[l] = VECTORING ? in_data[l].y[CW-1] : ~in_data[l].z[CW-1];
            if (turn_pos[l])
            begin
                data_next[l].x = in_data[l].x - (in_data[l].y >>> STAGE);
                data_next[l].y = in_data[l].y + (in_data[l].x >>> STAGE);
                data_next[l].z = in_data[l].z - ARC;
            end
            else
            begin
                data_next[l].x = in_data[l].x + (in_data[l].y >>> STAGE);
                data_next[l].y = in_data[l].y - (in_data[l].x >>> STAGE);
                data_next[l].z = in_data[l].z + ARC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

@@ test/great_circle_midpoint_tb.sv @@
// self-checking testbench for the great-circle midpoint block
`timescale 1ns / 1ps

module great_circle_midpoint_tb
    import gcm_pkg::*;
();

    localparam int     RANDOM_PAIRS = 2000;
    localparam int     IDLE_LIMIT   = 5000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     STAGES       = DEFAULT_ROTATION_STAGES;
    localparam int     FRAC         = DEFAULT_ANGLE_FRACTION_BITS;
    localparam longint Q_TWO_PI     = 2 * Q_PI;
    localparam int     LAT_MAX      = 51472;
    localparam int     LON_MAX      = 102944;

    typedef struct {
        logic signed [LAT_W-1:0] lat1;
        logic signed [LON_W-1:0] lon1;
        logic signed [LAT_W-1:0] lat2;
        logic signed [LON_W-1:0] lon2;
        bit                      known;
        logic signed [LAT_W-1:0]     mid_lat;
        logic signed [MID_LON_W-1:0] mid_lon;
    } pair_t;

    typedef struct {
        logic signed [LAT_W-1:0]     lat;
        logic signed [MID_LON_W-1:0] lon;
    } midpoint_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    logic dst_stall = 1'b0;
    logic signed [LAT_W-1:0] start_latitude = '0;
    logic signed [LON_W-1:0] start_longitude = '0;
    logic signed [LAT_W-1:0] end_latitude = '0;
    logic signed [LON_W-1:0] end_longitude = '0;
    logic src_stall;
    logic dst_valid;
    logic signed [LAT_W-1:0]     middle_latitude;
    logic signed [MID_LON_W-1:0] middle_longitude;

    midpoint_t midpoints_due[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        quiet = 0;
    bit        long_hold = 0;

    great_circle_midpoint dut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall),
        .start_latitude(start_latitude), .start_longitude(start_longitude),
        .end_latitude(end_latitude), .end_longitude(end_longitude),
        .dst_valid(dst_valid), .dst_stall(dst_stall),
        .middle_latitude(middle_latitude), .middle_longitude(middle_longitude)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (WORK_BITS - 1))) >>> WORK_BITS;
    endfunction

    function automatic void rotate_sin_cos(input longint theta, output longint s,
                                           output longint c);
        bit     flip;
        longint x, y, dx, dy;
        flip = 0;
        x = Q_ONE;
        y = 0;
        while (theta > Q_PI)
            theta -= Q_TWO_PI;
        while (theta <= -Q_PI)
            theta += Q_TWO_PI;
        if (theta > Q_HALF_PI)
        begin
            theta -= Q_PI;
            flip = 1;
        end
        else if (theta < -Q_HALF_PI)
        begin
            theta += Q_PI;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (theta >= 0)
            begin
                x -= dx; y += dy; theta -= ARC_TABLE[i];
            end
            else
            begin
                x += dx; y -= dy; theta += ARC_TABLE[i];
            end
        end
        x = q30_mul(x, Q_INV_GAIN);
        y = q30_mul(y, Q_INV_GAIN);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring atan2 in q30, with the gain-corrected length
    function automatic longint vector_arc(input longint y, input longint x,
                                          output longint len);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
        begin
            len = 0;
            return 0;
        end
        if (x < 0)
        begin
            z = (y >= 0) ? Q_PI : -Q_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ARC_TABLE[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARC_TABLE[i];
            end
        end
        len = q30_mul(x, Q_INV_GAIN);
        return z;
    endfunction

    function automatic longint q30_to_angle(input longint z);
        return (z + (64'sd1 <<< (WORK_BITS - FRAC - 1))) >>> (WORK_BITS - FRAC);
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -(64'sd1 <<< (w - 1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic midpoint_t compute_midpoint(input pair_t p);
        longint s1, c1, s2, c2, sd, cd, bx, by, cx, norm, unused, zlat, zlon;
        midpoint_t m;
        rotate_sin_cos(longint'(p.lat1) <<< (WORK_BITS - FRAC), s1, c1);
        rotate_sin_cos(longint'(p.lat2) <<< (WORK_BITS - FRAC), s2, c2);
        rotate_sin_cos((longint'(p.lon2) - longint'(p.lon1)) <<< (WORK_BITS - FRAC), sd, cd);
        bx = q30_mul(c2, cd);
        by = q30_mul(c2, sd);
        cx = c1 + bx;
        zlon = vector_arc(by, cx, norm);
        zlat = vector_arc(s1 + s2, norm, unused);
        m.lat = LAT_W'(clamp(q30_to_angle(zlat), LAT_W));
        m.lon = MID_LON_W'(clamp(longint'(p.lon1) + q30_to_angle(zlon), MID_LON_W));
        return m;
    endfunction

    // mostly inside the stated range, now and then any bit pattern
    function automatic longint draw_angle(input int w, input int lim);
        longint r;
        r = longint'($urandom);
        if ($urandom_range(0, 9) == 0)
            return (r <<< (64 - w)) >>> (64 - w);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? lim : -lim;
            1: return longint'($urandom_range(0, 64)) - 32;
            default: return longint'($urandom_range(0, 2 * lim)) - lim;
        endcase
    endfunction

    function automatic pair_t draw_pair();
        pair_t p;
        p.known = 0;
        p.lat1 = LAT_W'(draw_angle(LAT_W, LAT_MAX));
        p.lon1 = LON_W'(draw_angle(LON_W, LON_MAX));
        p.lat2 = LAT_W'(draw_angle(LAT_W, LAT_MAX));
        p.lon2 = LON_W'(draw_angle(LON_W, LON_MAX));
        case ($urandom_range(0, 7))
            0:
            begin
                p.lat2 = p.lat1;
                p.lon2 = p.lon1;
            end
            1:
            begin
                // near-antipodal pair
                p.lat2 = -p.lat1;
                p.lon2 = LON_W'(longint'(p.lon1) + LON_MAX + $urandom_range(0, 8) - 4);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input pair_t p, input bit no_gap);
        int gap;
        gap = (quiet || no_gap) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        start_latitude <= p.lat1;
        start_longitude <= p.lon1;
        end_latitude <= p.lat2;
        end_longitude <= p.lon2;
        do
            @(posedge clk);
        while (src_stall);
        if (p.known)
            midpoints_due.push_back('{lat: p.mid_lat, lon: p.mid_lon});
        else
            midpoints_due.push_back(compute_midpoint(p));
    endtask

    pair_t directed[] = '{
        '{0, 0, 0, 0, 0, 0, 0},
        '{LAT_MAX, 0, LAT_MAX, 0, 0, 0, 0},
        '{-LAT_MAX, 0, -LAT_MAX, 0, 0, 0, 0},
        '{LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 0, 0, 0},
        '{0, 0, 0, LON_MAX, 0, 0, 0},
        '{0, -LON_MAX, 0, LON_MAX, 0, 0, 0},
        '{0, 0, 0, 60000, 0, 0, 0},
        '{0, 0, 0, -60000, 0, 0, 0},
        '{12000, -LON_MAX, -30000, LON_MAX, 0, 0, 0},
        '{-65536, -131072, -65536, -131072, 0, 0, 0},
        '{65535, 131071, 65535, 131071, 0, 0, 0},
        '{65535, -131072, -65536, 131071, 0, 0, 0},
        '{-65536, 131071, 65535, -131072, 0, 0, 0},
        '{0, 131071, 0, 131071, 0, 0, 0},
        '{0, -131072, 0, -131072, 0, 0, 0},
        '{20000, 51472, 20000, 51472, 0, 0, 0},
        '{-3, 7, 5, -9, 0, 0, 0}
    };

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_pair(directed[i], 0);
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            if (n % 200 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            // hold the output off and stream back to back until the input stalls
            if (n == 700)
                long_hold = 1;
            send_pair(draw_pair(), n >= 700 && n < 760);
        end
        src_valid <= 1'b0;
        while (midpoints_due.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("great_circle_midpoint regression: pass");
        else
            $display("great_circle_midpoint regression: fail");
        $finish;
    end

    initial
    begin
        int n;
        forever
        begin
            if (long_hold)
            begin
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 0;
            end
            n = quiet ? 0 : $urandom_range(0, 15);
            if (n > 0)
            begin
                dst_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            dst_stall <= 1'b0;
            do
                @(posedge clk);
            while (!dst_valid && !long_hold);
        end
    end

    always @(posedge clk)
    begin
        midpoint_t exp_mid;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (midpoints_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat lat %0d lon %0d", $time,
                         middle_latitude, middle_longitude);
            end
            else
            begin
                exp_mid = midpoints_due.pop_front();
                if (middle_latitude !== exp_mid.lat)
                begin
                    errors++;
                    $display("%0t: middle_latitude expected %0d got %0d", $time,
                             exp_mid.lat, middle_latitude);
                end
                if (middle_longitude !== exp_mid.lon)
                begin
                    errors++;
                    $display("%0t: middle_longitude expected %0d got %0d", $time,
                             exp_mid.lon, middle_longitude);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("great_circle_midpoint regression: fail");
            $finish;
        end
    end

endmodule
